// File: design/csmh_pkg.sv
// Shared constants, types and the bin-edge table for the complex-sum
// magnitude histogram. No dependencies.
`default_nettype none

package csmh_pkg;

  localparam int MAX_BINS    = 64;
  localparam int BIN_W       = $clog2(MAX_BINS);
  localparam int NB_W        = 7;
  localparam int NB_SQ_W     = 2 * NB_W - 1;
  localparam int CNT_W       = 21;
  localparam int MAX_SAMPLES = 1048576;
  localparam int SAMP_W      = 16;
  localparam int SUM_W       = SAMP_W + 2;
  localparam int MAG_W       = SAMP_W;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int M2_W        = SQ_W + 1;
  localparam int PROD_W      = SQ_W + NB_SQ_W;
  // (3.0 in Q3.14)^2 = 9 * 2^28: compare bins on the product shifted by 28
  localparam int Q_LSB       = 28;
  localparam int Q_W         = PROD_W - Q_LSB;
  localparam int EDGE_W      = 16;

  localparam logic [MAG_W:0]    XMAX_RAW = 17'd49152;
  localparam logic [M2_W-1:0]   M2_LIM   = 33'd2415919104;
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_SAMPLES);
  localparam logic [NB_W-1:0]   NB_MAX   = NB_W'(MAX_BINS);

  typedef logic [BIN_W-1:0] bin_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Squared lower edge of bin k in units of 2^28: 9 * k * k
  function automatic logic [EDGE_W-1:0] bin_edge_sq(input bin_t k);
    logic [EDGE_W-1:0] kk;
    kk = EDGE_W'(k) * EDGE_W'(k);
    return EDGE_W'(kk * EDGE_W'(9));
  endfunction

endpackage

`default_nettype wire

// File: design/complex_sum_magnitude_histogram_unit.sv
// Top level of the complex-sum magnitude histogram: binning pipeline,
// bin counter memory with read-modify-write, and readout sequencer.
// Depends on csmh_pkg.
//
// Channel   Dir  Width  Contents
// s_axis    in   96+1   tdata: re_a im_a re_b im_b re_c im_c; tlast: final_site
// m_axis    out  32+1   tdata: bin_index bin_count; tlast: last_bin
// num_bins  in   7      write enable + data, bin count clamped to 1..64
//
// Samples enter one per cycle while intake is open; each passes the binning
// pipeline registers to the counter memory and is counted through a read and
// write-back, with forwarding between back-to-back updates. A final_site
// transfer closes intake until the pipeline drains and num_bins results have
// been transferred, one per cycle while m_axis_tready holds. Reset clears all
// counters at once through per-bin valid flags; the same flags clear the store after readout.
`default_nettype none

module complex_sum_magnitude_histogram_unit import csmh_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [95:0]       s_axis_tdata,  // re_a, im_a, re_b, im_b, re_c, im_c
  input  wire logic              s_axis_tlast,  // final_site
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [31:0]            m_axis_tdata,  // bin_index[5:0], bin_count[26:6], zero
  output logic                   m_axis_tlast,  // last_bin
  input  wire logic              num_bins_wr_en,
  input  wire logic [NB_W-1:0]   num_bins_wr_data
);

  localparam logic [1:0] ST_BIN   = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0]          state;
  logic [NB_W-1:0]     num_bins;
  logic [NB_SQ_W-1:0]  nb_sq;
  logic [NB_W-1:0]     nb_clamp;

  // ---------------- configuration ----------------
  always_comb begin
    nb_clamp = num_bins_wr_data;
    if (num_bins_wr_data == '0) nb_clamp = NB_W'(1);
    else if (num_bins_wr_data > NB_MAX) nb_clamp = NB_MAX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_bins <= NB_MAX;
      nb_sq    <= NB_SQ_W'(NB_MAX) * NB_SQ_W'(NB_MAX);
    end else if (num_bins_wr_en) begin
      num_bins <= nb_clamp;
      nb_sq    <= NB_SQ_W'(nb_clamp) * NB_SQ_W'(nb_clamp);
    end
  end

  // ---------------- stage 1: complex sums ----------------
  logic                     in_xfer;
  logic                     p1_v, p1_last;
  logic signed [SUM_W-1:0]  p1_re, p1_im;

  assign s_axis_tready = (state == ST_BIN);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  function automatic logic signed [SUM_W-1:0] sx(input logic [SAMP_W-1:0] v);
    return SUM_W'(signed'(v));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) p1_v <= 1'b0;
    else     p1_v <= in_xfer;
    p1_last <= s_axis_tlast;
    p1_re   <= sx(s_axis_tdata[15:0])  + sx(s_axis_tdata[47:32]) + sx(s_axis_tdata[79:64]);
    p1_im   <= sx(s_axis_tdata[31:16]) + sx(s_axis_tdata[63:48]) + sx(s_axis_tdata[95:80]);
  end

  // ---------------- stage 2: magnitudes of the parts, coarse range check ----
  logic [MAG_W:0]    abs_re, abs_im;
  logic              p2_v, p2_last, p2_drop;
  logic [MAG_W-1:0]  p2_are, p2_aim;

  assign abs_re = p1_re[SUM_W-1] ? (MAG_W+1)'(-p1_re) : (MAG_W+1)'(p1_re);
  assign abs_im = p1_im[SUM_W-1] ? (MAG_W+1)'(-p1_im) : (MAG_W+1)'(p1_im);

  always_ff @(posedge clk) begin
    if (rst) p2_v <= 1'b0;
    else     p2_v <= p1_v;
    p2_last <= p1_last;
    p2_drop <= (abs_re >= XMAX_RAW) || (abs_im >= XMAX_RAW);
    p2_are  <= abs_re[MAG_W-1:0];
    p2_aim  <= abs_im[MAG_W-1:0];
  end

  // ---------------- stage 3: squares ----------------
  logic             p3_v, p3_last, p3_drop;
  logic [SQ_W-1:0]  p3_sre, p3_sim;

  always_ff @(posedge clk) begin
    if (rst) p3_v <= 1'b0;
    else     p3_v <= p2_v;
    p3_last <= p2_last;
    p3_drop <= p2_drop;
    p3_sre  <= SQ_W'(p2_are) * SQ_W'(p2_are);
    p3_sim  <= SQ_W'(p2_aim) * SQ_W'(p2_aim);
  end

  // ---------------- stage 4: squared magnitude, exact range check ----------
  logic [M2_W-1:0]  m2;
  logic             p4_v, p4_last, p4_drop;
  logic [SQ_W-1:0]  p4_m2;

  assign m2 = M2_W'(p3_sre) + M2_W'(p3_sim);

  always_ff @(posedge clk) begin
    if (rst) p4_v <= 1'b0;
    else     p4_v <= p3_v;
    p4_last <= p3_last;
    p4_drop <= p3_drop || (m2 >= M2_LIM);
    p4_m2   <= m2[SQ_W-1:0];
  end

  // ---------------- stage 5: scale by num_bins^2 ----------------
  logic [PROD_W-1:0] prod;
  assign prod = PROD_W'(p4_m2) * PROD_W'(nb_sq);

  // ---------------- bin search: one bit per stage, MSB first ----------------
  logic             sr_v    [0:BIN_W];
  logic             sr_last [0:BIN_W];
  logic             sr_drop [0:BIN_W];
  bin_t             sr_k    [0:BIN_W];
  logic [Q_W-1:0]   sr_q    [0:BIN_W];

  always_ff @(posedge clk) begin
    if (rst) sr_v[0] <= 1'b0;
    else     sr_v[0] <= p4_v;
    sr_last[0] <= p4_last;
    sr_drop[0] <= p4_drop;
    sr_k[0]    <= '0;
    sr_q[0]    <= prod[PROD_W-1:Q_LSB];
  end

  for (genvar j = 0; j < BIN_W; j++) begin : g_search
    bin_t cand;
    assign cand = sr_k[j] | (bin_t'(1) << (BIN_W - 1 - j));

    always_ff @(posedge clk) begin
      if (rst) sr_v[j+1] <= 1'b0;
      else     sr_v[j+1] <= sr_v[j];
      sr_last[j+1] <= sr_last[j];
      sr_drop[j+1] <= sr_drop[j];
      sr_q[j+1]    <= sr_q[j];
      sr_k[j+1]    <= (Q_W'(bin_edge_sq(cand)) <= sr_q[j]) ? cand : sr_k[j];
    end
  end

  // counter memory: read-first, registered read
  cnt_t                 cnt_mem [0:MAX_BINS-1];
  logic [MAX_BINS-1:0]  live;
  cnt_t                 rd_q;
  logic                 live_q;
  logic                 rd_en;
  bin_t                 rd_addr;
  logic                 wr_en;
  bin_t                 wr_addr;
  cnt_t                 wr_data;
  logic                 ro_issue, ro_clear;
  logic [NB_W-1:0]      ro_idx;

  assign rd_en   = sr_v[BIN_W] || ro_issue;
  assign rd_addr = (state == ST_READ) ? ro_idx[BIN_W-1:0] : sr_k[BIN_W];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q   <= cnt_mem[rd_addr];
      live_q <= live[rd_addr];
    end
    if (wr_en) cnt_mem[wr_addr] <= wr_data;
  end

  // per-bin valid flags: unset bins read as zero
  always_ff @(posedge clk) begin
    if (rst || ro_clear) live <= '0;
    else if (wr_en)      live[wr_addr] <= 1'b1;
  end

  // ---------------- update stage with forwarding ----------------
  logic  u_v, u_last, u_drop;
  bin_t  u_bin;
  logic  fwd_v;
  bin_t  fwd_addr;
  cnt_t  fwd_data;
  cnt_t  cur;

  always_ff @(posedge clk) begin
    if (rst) u_v <= 1'b0;
    else     u_v <= sr_v[BIN_W];
    u_last <= sr_last[BIN_W];
    u_drop <= sr_drop[BIN_W];
    u_bin  <= sr_k[BIN_W];
  end

  // a write at the edge of our read is not in rd_q: take it from fwd_data
  always_comb begin
    if (fwd_v && (fwd_addr == u_bin)) cur = fwd_data;
    else if (live_q)                  cur = rd_q;
    else                              cur = '0;
  end

  assign wr_en   = u_v && !u_drop;
  assign wr_addr = u_bin;
  assign wr_data = (cur < CNT_MAX) ? cur + cnt_t'(1) : cur;

  always_ff @(posedge clk) begin
    if (rst) fwd_v <= 1'b0;
    else     fwd_v <= wr_en;
    fwd_addr <= wr_addr;
    fwd_data <= wr_data;
  end

  // ---------------- readout ----------------
  logic   adv;
  logic   ro_v, ro_last;
  bin_t   ro_bin;
  logic   out_xfer;

  assign adv      = !m_axis_tvalid || m_axis_tready;
  assign ro_issue = (state == ST_READ) && (ro_idx < num_bins) && adv;
  assign ro_clear = ro_issue && (ro_idx == num_bins - NB_W'(1));
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ro_v          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      ro_v          <= ro_issue;
      m_axis_tvalid <= ro_v;
    end
    if (ro_issue) begin
      ro_bin  <= ro_idx[BIN_W-1:0];
      ro_last <= (ro_idx == num_bins - NB_W'(1));
    end
    if (adv) begin
      m_axis_tdata <= {5'd0, (live_q ? rd_q : cnt_t'(0)), ro_bin};
      m_axis_tlast <= ro_last;
    end
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_BIN;
      ro_idx <= '0;
    end else begin
      unique case (state)
        ST_BIN: begin
          if (in_xfer && s_axis_tlast) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          ro_idx <= '0;
          if (u_v && u_last) state <= ST_READ;
        end
        ST_READ: begin
          if (ro_issue) ro_idx <= ro_idx + NB_W'(1);
          if (out_xfer && m_axis_tlast) state <= ST_BIN;
        end
        default: state <= ST_BIN;
      endcase
    end
  end

  // ---------------- assertions ----------------
  a_no_update_in_readout: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !wr_en)
    else $error("counter update during readout");

  a_out_only_in_readout: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (state == ST_READ) && !s_axis_tready)
    else $error("result outside readout");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |->
      (NB_W'(m_axis_tdata[BIN_W-1:0]) == num_bins - NB_W'(1)))
    else $error("last_bin on wrong index");

  a_clear_after_readout: assert property (@(posedge clk) disable iff (rst)
    ro_clear |=> (live == '0))
    else $error("counters not cleared after readout");

endmodule

`default_nettype wire
